// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define SETQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a consequent holds in the cycle of its antecedent.
`define SETQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ((ante) |-> (cons))) \
    else $error(msg);
`else
`define SETQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SETQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/setq_pkg.sv =====
// Shared types and constants for the sorted expiry timer queue.
// Used by setq_cell, setq_ctrl and the top level; depends on nothing.
package setq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int EXP_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int PEND_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE          = 3'd0,
    STS_FULL          = 3'd1,
    STS_NOT_FOUND     = 3'd2,
    STS_DUPLICATE     = 3'd3,
    STS_EXPIRED       = 3'd4,
    STS_NONE_EXPIRED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_APPLY,
    ST_TICK
  } state_t;

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_COMPARE,
    ACT_MOVE,
    ACT_WRITE_EXP,
    ACT_SHIFT_LEFT
  } act_t;

  typedef struct packed {
    act_t             action;
    logic [ID_W-1:0]  key_id;
    logic [EXP_W-1:0] key_exp;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  // What a cell hands to its neighbors
  typedef struct packed {
    logic             less;
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] exp;
  } cell_link_t;

  typedef struct packed {
    logic match;
    logic ok;
  } cell_flags_t;

  // Row summary seen by the controller
  typedef struct packed {
    logic             any_match;
    logic             any_ok;
    logic [CNT_W-1:0] match_pos;
    logic [ID_W-1:0]  head_id;
    logic [EXP_W-1:0] head_exp;
    logic [EXP_W-1:0] next_exp;
  } cell_sum_t;

  typedef struct packed {
    logic              strobe;
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [PEND_W-1:0] pending;
    logic              last;
  } result_t;

  // Boundary links: the head sees an always-smaller neighbor, the tail an empty one
  localparam cell_link_t LINK_HEAD = '{less: 1'b1, id: '0, exp: '0};
  localparam cell_link_t LINK_TAIL = '{less: 1'b0, id: '0, exp: '0};

endpackage

// ===== rtl/core/setq_cell.sv =====
// One slot of the sorted timer row: holds an id, its expiry and compare flags.
// Depends on setq_pkg; trades data with its left and right neighbors.
module setq_cell (
  input  logic                         clk,
  input  logic [setq_pkg::CNT_W-1:0]   cell_idx,
  input  setq_pkg::cell_ctl_t          ctl,
  input  setq_pkg::cell_link_t         left_in,
  input  setq_pkg::cell_link_t         right_in,
  output setq_pkg::cell_link_t         link_out,
  output setq_pkg::cell_flags_t        flags_out
);

  logic [setq_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [setq_pkg::EXP_W-1:0] exp_r, exp_nxt;
  logic                       less_r, less_nxt;
  logic                       match_r, match_nxt;
  logic                       ok_r, ok_nxt;
  logic                       occ, right_occ, hit, lt, eq;

  // Occupancy and key match for this slot
  assign occ       = cell_idx < ctl.count;
  assign right_occ = (cell_idx + setq_pkg::CNT_W'(1)) < ctl.count;
  assign hit       = occ && (id_r == ctl.key_id);
  assign lt        = cell_idx < ctl.pos;
  assign eq        = cell_idx == ctl.pos;

  // Select the next slot contents for the broadcast operation
  always_comb begin
    id_nxt    = id_r;
    exp_nxt   = exp_r;
    less_nxt  = less_r;
    match_nxt = match_r;
    ok_nxt    = ok_r;
    case (ctl.action)
      setq_pkg::ACT_COMPARE: begin
        less_nxt  = occ && !hit && (exp_r < ctl.key_exp);
        match_nxt = hit;
        ok_nxt    = hit && (left_in.exp <= ctl.key_exp) &&
                    (!right_occ || (ctl.key_exp <= right_in.exp));
      end
      setq_pkg::ACT_MOVE: begin
        // Vacate slot pos and open a gap after the last smaller expiry
        if (lt) begin
          if (!less_r) begin
            if (left_in.less) begin
              id_nxt  = ctl.key_id;
              exp_nxt = ctl.key_exp;
            end else begin
              id_nxt  = left_in.id;
              exp_nxt = left_in.exp;
            end
          end
        end else if (eq) begin
          if (right_in.less) begin
            id_nxt  = right_in.id;
            exp_nxt = right_in.exp;
          end else if (left_in.less) begin
            id_nxt  = ctl.key_id;
            exp_nxt = ctl.key_exp;
          end else begin
            id_nxt  = left_in.id;
            exp_nxt = left_in.exp;
          end
        end else begin
          if (right_in.less) begin
            id_nxt  = right_in.id;
            exp_nxt = right_in.exp;
          end else if (less_r) begin
            id_nxt  = ctl.key_id;
            exp_nxt = ctl.key_exp;
          end
        end
      end
      setq_pkg::ACT_WRITE_EXP: begin
        if (match_r) begin
          exp_nxt = ctl.key_exp;
        end
      end
      setq_pkg::ACT_SHIFT_LEFT: begin
        if (!lt) begin
          id_nxt  = right_in.id;
          exp_nxt = right_in.exp;
        end
      end
      default: begin
      end
    endcase
  end

  // Slot storage carries no reset; the held count marks what is valid
  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    exp_r   <= exp_nxt;
    less_r  <= less_nxt;
    match_r <= match_nxt;
    ok_r    <= ok_nxt;
  end

  assign link_out.less  = less_r;
  assign link_out.id    = id_r;
  assign link_out.exp   = exp_r;
  assign flags_out.match = match_r;
  assign flags_out.ok    = ok_r;

endmodule

// ===== rtl/core/setq_ctrl.sv =====
// Command sequencer for the timer queue: accepts commands, drives the cell row
// and registers results. Depends on setq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module setq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [setq_pkg::CMD_W-1:0]    cmd_in,
  input  logic [setq_pkg::ID_W-1:0]     id_in,
  input  logic [setq_pkg::EXP_W-1:0]    exp_in,
  input  logic [setq_pkg::EXP_W-1:0]    now_in,
  input  setq_pkg::cell_sum_t           sum,
  output setq_pkg::cell_ctl_t           ctl,
  output setq_pkg::result_t             res
);

  setq_pkg::state_t               state_r, state_nxt;
  setq_pkg::cmd_t                 cmd_r;
  logic [setq_pkg::ID_W-1:0]      id_r;
  logic [setq_pkg::EXP_W-1:0]     exp_r;
  logic [setq_pkg::EXP_W-1:0]     now_r;
  logic [setq_pkg::CNT_W-1:0]     count_r, count_nxt;
  setq_pkg::result_t              res_r, res_nxt;
  setq_pkg::act_t                 action;
  logic [setq_pkg::CNT_W-1:0]     pos;
  logic                           accept, head_due, next_due;

  assign busy   = state_r != setq_pkg::ST_IDLE;
  assign accept = start && !busy;

  // Due checks on the two earliest timers
  assign head_due = (count_r != '0) && (sum.head_exp <= now_r);
  assign next_due = (count_r > setq_pkg::CNT_W'(1)) && (sum.next_exp <= now_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      setq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (setq_pkg::cmd_t'(cmd_in) == setq_pkg::CMD_TICK) ?
                      setq_pkg::ST_TICK : setq_pkg::ST_COMPARE;
        end
      end
      setq_pkg::ST_COMPARE: state_nxt = setq_pkg::ST_APPLY;
      setq_pkg::ST_APPLY:   state_nxt = setq_pkg::ST_IDLE;
      setq_pkg::ST_TICK: begin
        if (!head_due || !next_due) begin
          state_nxt = setq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = setq_pkg::ST_IDLE;
    endcase
  end

  // Outputs: cell operation, count update and result
  always_comb begin
    action          = setq_pkg::ACT_IDLE;
    pos             = '0;
    count_nxt       = count_r;
    res_nxt.strobe  = 1'b0;
    res_nxt.status  = setq_pkg::STS_DONE;
    res_nxt.id      = '0;
    res_nxt.last    = 1'b1;
    case (state_r)
      setq_pkg::ST_COMPARE: action = setq_pkg::ACT_COMPARE;
      setq_pkg::ST_APPLY: begin
        res_nxt.strobe = 1'b1;
        case (cmd_r)
          setq_pkg::CMD_ADD: begin
            if (sum.any_match) begin
              res_nxt.status = setq_pkg::STS_DUPLICATE;
            end else if (count_r >= setq_pkg::CNT_W'(setq_pkg::CAPACITY)) begin
              res_nxt.status = setq_pkg::STS_FULL;
            end else begin
              action    = setq_pkg::ACT_MOVE;
              pos       = count_r;
              count_nxt = count_r + setq_pkg::CNT_W'(1);
            end
          end
          setq_pkg::CMD_ADJUST: begin
            if (!sum.any_match) begin
              res_nxt.status = setq_pkg::STS_NOT_FOUND;
            end else if (sum.any_ok) begin
              action = setq_pkg::ACT_WRITE_EXP;
            end else begin
              action = setq_pkg::ACT_MOVE;
              pos    = sum.match_pos;
            end
          end
          setq_pkg::CMD_DELETE: begin
            if (!sum.any_match) begin
              res_nxt.status = setq_pkg::STS_NOT_FOUND;
            end else begin
              action    = setq_pkg::ACT_SHIFT_LEFT;
              pos       = sum.match_pos;
              count_nxt = count_r - setq_pkg::CNT_W'(1);
            end
          end
          default: res_nxt.strobe = 1'b0;
        endcase
      end
      setq_pkg::ST_TICK: begin
        res_nxt.strobe = 1'b1;
        if (head_due) begin
          // Pop the head timer and advance the row
          action         = setq_pkg::ACT_SHIFT_LEFT;
          count_nxt      = count_r - setq_pkg::CNT_W'(1);
          res_nxt.status = setq_pkg::STS_EXPIRED;
          res_nxt.id     = sum.head_id;
          res_nxt.last   = !next_due;
        end else begin
          res_nxt.status = setq_pkg::STS_NONE_EXPIRED;
        end
      end
      default: begin
      end
    endcase
    res_nxt.pending = setq_pkg::PEND_W'(count_nxt);
  end

  // Control state and result register; of the result fields only the strobe is reset
  always_ff @(posedge clk) begin
    res_r.status  <= res_nxt.status;
    res_r.id      <= res_nxt.id;
    res_r.pending <= res_nxt.pending;
    res_r.last    <= res_nxt.last;
    if (!rst_n) begin
      state_r       <= setq_pkg::ST_IDLE;
      count_r       <= '0;
      res_r.strobe  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      res_r.strobe  <= res_nxt.strobe;
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= setq_pkg::cmd_t'(cmd_in);
      id_r  <= id_in;
      exp_r <= exp_in;
      now_r <= now_in;
    end
  end

  assign ctl.action  = action;
  assign ctl.key_id  = id_r;
  assign ctl.key_exp = exp_r;
  assign ctl.pos     = pos;
  assign ctl.count   = count_r;
  assign res         = res_r;

  `SETQ_ASSERT(a_count_bound, clk, rst_n, count_r <= setq_pkg::CNT_W'(setq_pkg::CAPACITY), "held count exceeds capacity")
  `SETQ_ASSERT(a_accept_busy, clk, rst_n, accept |=> busy, "accepted transaction did not raise busy")
  `SETQ_ASSERT_IMP(a_pop_count, clk, rst_n, res_r.strobe && (res_r.status == setq_pkg::STS_EXPIRED), (count_r + setq_pkg::CNT_W'(1)) == $past(count_r), "pop did not drop count by one")
  `SETQ_ASSERT_IMP(a_strobe_busy, clk, rst_n, res_r.strobe, $past(state_r != setq_pkg::ST_IDLE), "result without a transaction in progress")

endmodule

// ===== rtl/core/sorted_expiry_timer_queue.sv =====
// Top level of the sorted expiry timer queue: a row of timer cells under
// one command sequencer. Depends on setq_pkg, setq_cell and setq_ctrl.
//
// Usage:
//   Raise start with in_command and its operands; the transaction is taken
//   on a rising edge where start is high and busy is low. Add, adjust and
//   delete run a compare across all cells, then one shift or write step,
//   and give one result, which appears on the out_ ports for one cycle with
//   out_strobe high, the cycle after the second step.
//   A tick pops every due timer, or reports that none is due, and gives one
//   result per cycle, earliest first, with out_last on the final one.
//   The one-step shift of the cell row sets the pop rate.
//   A new transaction may be taken while the previous result is on the
//   out_ ports. Results cannot be held off: each is valid for its single
//   strobe cycle only.
//   Reset (rst_n low, synchronous) empties the queue and returns to idle;
//   the slot contents themselves are not cleared.
module sorted_expiry_timer_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [setq_pkg::CMD_W-1:0]      in_command,
  input  logic [setq_pkg::ID_W-1:0]       in_conn_id,
  input  logic [setq_pkg::EXP_W-1:0]      in_expiry_time,
  input  logic [setq_pkg::EXP_W-1:0]      in_current_time,
  output logic                            out_strobe,
  output logic [setq_pkg::STATUS_W-1:0]   out_status,
  output logic [setq_pkg::ID_W-1:0]       out_expired_id,
  output logic [setq_pkg::PEND_W-1:0]     out_pending_count,
  output logic                            out_last
);

  setq_pkg::cell_ctl_t    ctl;
  setq_pkg::cell_sum_t    sum;
  setq_pkg::result_t      res;
  setq_pkg::cell_link_t   link  [setq_pkg::CAPACITY];
  setq_pkg::cell_flags_t  flags [setq_pkg::CAPACITY];
  logic                   any_match, any_ok;
  logic [setq_pkg::CNT_W-1:0] match_pos;

  setq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd_in (in_command),
    .id_in  (in_conn_id),
    .exp_in (in_expiry_time),
    .now_in (in_current_time),
    .sum    (sum),
    .ctl    (ctl),
    .res    (res)
  );

  // Row of cells, each wired to its neighbors
  for (genvar g = 0; g < setq_pkg::CAPACITY; g++) begin : g_cell
    setq_pkg::cell_link_t left_link, right_link;
    if (g == 0) begin : g_head
      assign left_link = setq_pkg::LINK_HEAD;
    end else begin : g_left
      assign left_link = link[g-1];
    end
    if (g == setq_pkg::CAPACITY - 1) begin : g_tail
      assign right_link = setq_pkg::LINK_TAIL;
    end else begin : g_right
      assign right_link = link[g+1];
    end
    setq_cell u_cell (
      .clk       (clk),
      .cell_idx  (setq_pkg::CNT_W'(g)),
      .ctl       (ctl),
      .left_in   (left_link),
      .right_in  (right_link),
      .link_out  (link[g]),
      .flags_out (flags[g])
    );
  end

  // Reduce the per-cell flags; ids are unique so at most one cell matches
  always_comb begin
    any_match = 1'b0;
    any_ok    = 1'b0;
    match_pos = '0;
    for (int i = 0; i < setq_pkg::CAPACITY; i++) begin
      any_match = any_match | flags[i].match;
      any_ok    = any_ok | flags[i].ok;
      if (flags[i].match) begin
        match_pos = match_pos | setq_pkg::CNT_W'(i);
      end
    end
  end

  assign sum.any_match = any_match;
  assign sum.any_ok    = any_ok;
  assign sum.match_pos = match_pos;
  assign sum.head_id   = link[0].id;
  assign sum.head_exp  = link[0].exp;
  assign sum.next_exp  = link[1].exp;

  assign out_strobe        = res.strobe;
  assign out_status        = res.status;
  assign out_expired_id    = res.id;
  assign out_pending_count = res.pending;
  assign out_last          = res.last;

endmodule
